// ===== hw/rtl/acle_pkg.sv =====
// shared codes, characters and item type for the command line editor
`default_nettype none

package acle_pkg;

	// operation handed from the front to the back
	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_END   = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_ERASE = 3'd3;
	localparam logic [2:0] OP_STORE = 3'd4;

	// result action codes
	localparam logic [2:0] ACT_IGNORE = 3'd0;
	localparam logic [2:0] ACT_STORE  = 3'd1;
	localparam logic [2:0] ACT_ERASE  = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_END    = 3'd4;

	// line verdict codes
	localparam logic [2:0] V_NONE  = 3'd0;
	localparam logic [2:0] V_BLANK = 3'd1;
	localparam logic [2:0] V_OK    = 3'd2;
	localparam logic [2:0] V_CMD   = 3'd3;
	localparam logic [2:0] V_ERROR = 3'd4;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// one queued operation
	typedef struct packed {
		logic [2:0] code;
		logic [7:0] data;
	} op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/at_command_line_editor.sv =====
// top level of the serial command line editor
//
// Usage: received serial bytes enter on the rx channel (rx_valid, rx_ready,
// rx_byte), one byte per item. For every item exactly one result item leaves
// on the res channel (res_valid, res_ready) with action, echo_char,
// erase_count, verdict, cmd_start and line_length.
// The front decodes control bytes and filters escape sequences; a two-entry
// queue decouples it from the back, which owns the line store and the count.
// Throughput: an ordinary byte passes the queue and then the result register,
// and the block sustains one item per cycle for such bytes while res_ready is
// high. A line end (CR, LF or a byte that fills the store) scans the stored
// line with one read of the line store per cycle, until the line ends or four
// bytes after the leading spaces are held; no queued item is taken meanwhile.
// Reset: arst_n clears the line length, the escape phase, the queue and the
// result valid flag; the store contents are not cleared and need no clearing
// pass, since only written entries are ever read.
// Stall: a result waits in the output register until res_ready; the queue
// keeps taking bytes until it is full, then rx_ready drops.
`default_nettype none

module at_command_line_editor
	import acle_pkg::*;
#(
	parameter int LINE_MAX = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [2:0]      action,
	output logic [7:0]      echo_char,
	output logic [7:0]      erase_count,
	output logic [2:0]      verdict,
	output logic [6:0]      cmd_start,
	output logic [7:0]      line_length
);

	logic q_full;
	logic push;
	op_t  push_op;
	logic pop;
	logic q_valid;
	op_t  q_op;

	// byte decode and escape filter
	acle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.rx_ready (rx_ready),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	// decoupling queue
	acle_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_op    (q_op)
	);

	// line editing and classification
	acle_back #(
		.LINE_MAX (LINE_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_op        (q_op),
		.pop         (pop),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.action      (action),
		.echo_char   (echo_char),
		.erase_count (erase_count),
		.verdict     (verdict),
		.cmd_start   (cmd_start),
		.line_length (line_length)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/acle_front.sv =====
// front end: byte decode and escape sequence filter
`default_nettype none

module acle_front
	import acle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	input  wire logic [7:0] rx_byte,
	output logic            rx_ready,
	input  wire logic       q_full,
	output logic            push,
	output op_t             push_op
);

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_SEEN = 2'd1;
	localparam logic [1:0] ESC_CODE = 2'd2;

	logic [1:0] esc_q;
	logic [1:0] esc_d;

	assign rx_ready = !q_full;
	assign push     = rx_valid && rx_ready;

	// classify the byte against the escape phase
	always_comb begin
		esc_d        = esc_q;
		push_op.code = OP_NOP;
		push_op.data = rx_byte;
		unique case (rx_byte) inside
			CH_NUL: begin
				push_op.code = OP_NOP;
			end
			CH_LF, CH_CR: begin
				push_op.code = OP_END;
			end
			CH_TAB: begin
				push_op.code = OP_CLEAR;
			end
			CH_BS, CH_DEL: begin
				push_op.code = OP_ERASE;
			end
			CH_ESC: begin
				esc_d = ESC_SEEN;
			end
			default: begin
				if (esc_q == ESC_SEEN) begin
					esc_d = (rx_byte == CH_LBRK) ? ESC_CODE : ESC_NONE;
				end else if (esc_q == ESC_CODE) begin
					if (rx_byte < CH_ZERO || rx_byte > CH_NINE) begin
						esc_d = ESC_NONE;
					end
				end else begin
					push_op.code = OP_STORE;
				end
			end
		endcase
	end

	// escape phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_NONE;
		end else if (push) begin
			esc_q <= esc_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/acle_queue.sv =====
// two-entry item queue between front and back
`default_nettype none

module acle_queue
	import acle_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  op_t       push_op,
	output logic      full,
	input  wire logic pop,
	output logic      q_valid,
	output op_t       q_op
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_op    = slots_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/acle_back.sv =====
// back end: line store, edit execution, line scan and result register
`default_nettype none

module acle_back
	import acle_pkg::*;
#(
	parameter int LINE_MAX = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  op_t             q_op,
	output logic            pop,
	input  wire logic       res_ready,
	output logic            res_valid,
	output logic [2:0]      action,
	output logic [7:0]      echo_char,
	output logic [7:0]      erase_count,
	output logic [2:0]      verdict,
	output logic [6:0]      cmd_start,
	output logic [7:0]      line_length
);

	localparam int CNT_W = $clog2(LINE_MAX + 1);
	localparam int IDX_W = $clog2(LINE_MAX);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	// line storage
	logic [7:0]       mem [LINE_MAX];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [7:0]       rdata_q;

	// control state
	logic             state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] count_inc, count_dec;

	// scan state
	logic [CNT_W-1:0] scan_len_q, scan_len_d;
	logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] di_q, di_d, di_nx;
	logic             dv_q, dv_d;
	logic             grab_q, grab_d;
	logic [1:0]       k_q, k_d;
	logic [7:0]       chars_q [4];
	logic [7:0]       chars_d [4];
	logic [7:0]       cn [4];
	logic [IDX_W-1:0] start_q, start_d;
	logic [7:0]       echo_pend_q, echo_pend_d;
	logic             last;

	// result register
	logic             res_valid_q;
	logic             res_load;
	logic [2:0]       act_d;
	logic [7:0]       echo_d;
	logic [7:0]       erase_d;
	logic [2:0]       verd_d;
	logic [6:0]       cstart_d;
	logic [7:0]       len_d;
	logic [2:0]       act_q;
	logic [7:0]       echo_q;
	logic [7:0]       erase_q;
	logic [2:0]       verd_q;
	logic [6:0]       cstart_q;
	logic [7:0]       len_q;

	// verdict from the first four bytes after leading spaces
	function automatic logic [2:0] line_verdict(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3);
		logic [2:0] v;
		v = V_ERROR;
		if (c0 == CH_A && c1 == CH_T) begin
			if (c2 == CH_PLUS && c3 != CH_SP && c3 != CH_NUL) begin
				v = V_CMD;
			end else if (c2 == CH_NUL) begin
				v = V_OK;
			end
		end
		return v;
	endfunction

	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign di_nx     = di_q + 1'b1;
	assign last      = di_nx == scan_len_q;
	assign pop       = q_valid && state_q == ST_IDLE && (!res_valid_q || res_ready);

	// newly read byte merged into the captured bytes
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cn[i] = chars_q[i];
		end
		cn[grab_q ? k_q : 2'd0] = rdata_q;
	end

	// execution and scan control
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		mem_we      = 1'b0;
		mem_waddr   = count_q[IDX_W-1:0];
		scan_len_d  = scan_len_q;
		rd_ptr_d    = rd_ptr_q;
		di_d        = di_q;
		dv_d        = 1'b0;
		grab_d      = grab_q;
		k_d         = k_q;
		start_d     = start_q;
		echo_pend_d = echo_pend_q;
		for (int i = 0; i < 4; i++) begin
			chars_d[i] = chars_q[i];
		end
		res_load = 1'b0;
		act_d    = ACT_IGNORE;
		echo_d   = 8'd0;
		erase_d  = 8'd0;
		verd_d   = V_NONE;
		cstart_d = 7'd0;
		len_d    = 8'(count_q);
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					case (q_op.code)
						OP_END: begin
							count_d = '0;
							if (count_q == '0) begin
								res_load = 1'b1;
								act_d    = ACT_END;
								verd_d   = V_BLANK;
							end else begin
								state_d     = ST_SCAN;
								scan_len_d  = count_q;
								echo_pend_d = 8'd0;
							end
						end
						OP_CLEAR: begin
							count_d  = '0;
							res_load = 1'b1;
							act_d    = ACT_CLEAR;
							erase_d  = 8'(count_q);
							len_d    = 8'd0;
						end
						OP_ERASE: begin
							res_load = 1'b1;
							if (count_q != '0) begin
								count_d = count_dec;
								act_d   = ACT_ERASE;
								erase_d = 8'd1;
								len_d   = 8'(count_dec);
							end
						end
						OP_STORE: begin
							mem_we  = 1'b1;
							count_d = count_inc;
							if (count_inc == CNT_W'(LINE_MAX)) begin
								// full store ends the line
								count_d     = '0;
								state_d     = ST_SCAN;
								scan_len_d  = count_inc;
								echo_pend_d = q_op.data;
							end else begin
								res_load = 1'b1;
								act_d    = ACT_STORE;
								echo_d   = q_op.data;
								len_d    = 8'(count_inc);
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
					// fresh scan context
					rd_ptr_d = '0;
					grab_d   = 1'b0;
					k_d      = 2'd0;
					for (int i = 0; i < 4; i++) begin
						chars_d[i] = 8'd0;
					end
				end
			end
			ST_SCAN: begin
				// issue the next sequential read
				if (rd_ptr_q < scan_len_q) begin
					dv_d     = 1'b1;
					di_d     = rd_ptr_q;
					rd_ptr_d = rd_ptr_q + 1'b1;
				end
				// consume the byte read last cycle
				if (dv_q) begin
					if (!grab_q && rdata_q == CH_SP) begin
						if (last) begin
							state_d  = ST_IDLE;
							res_load = 1'b1;
							act_d    = ACT_END;
							echo_d   = echo_pend_q;
							verd_d   = V_BLANK;
							len_d    = 8'(scan_len_q);
						end
					end else begin
						for (int i = 0; i < 4; i++) begin
							chars_d[i] = cn[i];
						end
						if (!grab_q) begin
							start_d = di_q[IDX_W-1:0];
						end
						grab_d = 1'b1;
						k_d    = grab_q ? k_q + 2'd1 : 2'd1;
						if (last || (grab_q && k_q == 2'd3)) begin
							state_d  = ST_IDLE;
							res_load = 1'b1;
							act_d    = ACT_END;
							echo_d   = echo_pend_q;
							verd_d   = line_verdict(cn[0], cn[1], cn[2], cn[3]);
							cstart_d = grab_q ? 7'(start_q) : 7'(di_q);
							len_d    = 8'(scan_len_q);
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// line store write port and registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= q_op.data;
		end
		rdata_q <= mem[rd_ptr_q[IDX_W-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dv_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			dv_q    <= dv_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// scan context and result payload
	always_ff @(posedge clk) begin
		scan_len_q  <= scan_len_d;
		rd_ptr_q    <= rd_ptr_d;
		di_q        <= di_d;
		grab_q      <= grab_d;
		k_q         <= k_d;
		start_q     <= start_d;
		echo_pend_q <= echo_pend_d;
		for (int i = 0; i < 4; i++) begin
			chars_q[i] <= chars_d[i];
		end
		if (res_load) begin
			act_q    <= act_d;
			echo_q   <= echo_d;
			erase_q  <= erase_d;
			verd_q   <= verd_d;
			cstart_q <= cstart_d;
			len_q    <= len_d;
		end
	end

	assign res_valid   = res_valid_q;
	assign action      = act_q;
	assign echo_char   = echo_q;
	assign erase_count = erase_q;
	assign verdict     = verd_q;
	assign cmd_start   = cstart_q;
	assign line_length = len_q;

endmodule

`default_nettype wire

// ===== hw/rtl/acle_checker.sv =====
// port-level checks for the command line editor, bound to the top level
`default_nettype none

module acle_checker
	import acle_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [2:0] action,
	input wire logic [7:0] echo_char,
	input wire logic [7:0] erase_count,
	input wire logic [2:0] verdict,
	input wire logic [6:0] cmd_start,
	input wire logic [7:0] line_length
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(action) && $stable(echo_char)
			&& $stable(erase_count) && $stable(verdict) && $stable(cmd_start)
			&& $stable(line_length))
		else $error("result changed while stalled");

	// only an ended line carries a verdict and a start offset
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action != ACT_END |-> verdict == V_NONE && cmd_start == 7'd0)
		else $error("verdict without line end");

	// an ended line always has a verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action == ACT_END |-> verdict != V_NONE && erase_count == 8'd0)
		else $error("line end without verdict");

	// an ignored byte changes nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action == ACT_IGNORE |-> echo_char == 8'd0 && erase_count == 8'd0)
		else $error("ignored item with side effects");

	// erase removes exactly one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action == ACT_ERASE |-> erase_count == 8'd1 && echo_char == 8'd0)
		else $error("erase count wrong");

endmodule

bind at_command_line_editor acle_checker u_acle_checker (.*);

`default_nettype wire
